// ===== hdl/stlbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stlbs_pkg
// Shared types and codes for the sorted-table lower-bound search core.
// ----------------------------------------------------------------------------
`default_nettype none

package stlbs_pkg;

    localparam int ENTRY_COUNT_W = 9;
    localparam int ENTRY_INDEX_W = 8;
    localparam int VALUE_W       = 64;
    localparam int POSITION_W    = 8;

    // request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [VALUE_W-1:0]       entry_value;
        logic [VALUE_W-1:0]       search_key;
    } t_req;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_PROBE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept_write;
        logic accept_search;
        logic first;
        logic probe;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic key_le_first;
        logic hit;
        logic search_end;
    } t_dp_sts;

endpackage : stlbs_pkg

`default_nettype wire

// ===== hdl/stlbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stlbs_ctrl
// Sequencer for the search: first-entry check, then one probe per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stlbs_ctrl import stlbs_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_req_type,
    input  wire t_dp_sts i_sts,
    output logic         o_busy,
    output t_dp_cmd      o_cmd,
    output logic         o_rsp_valid
);

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   accept;

    assign accept = i_start & ~o_busy;

    // next state
    always_comb begin
        n_state     = r_state;
        n_rsp_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_req_type == REQ_SEARCH)) begin
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                if (i_sts.count_zero || i_sts.key_le_first) begin
                    n_state     = ST_IDLE;
                    n_rsp_valid = 1'b1;
                end else begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (i_sts.hit || i_sts.search_end) begin
                    n_state     = ST_IDLE;
                    n_rsp_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_busy              = 1'b1;
        o_cmd.accept_write  = 1'b0;
        o_cmd.accept_search = 1'b0;
        o_cmd.first         = 1'b0;
        o_cmd.probe         = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_busy              = 1'b0;
                o_cmd.accept_write  = i_start && (i_req_type == REQ_WRITE);
                o_cmd.accept_search = i_start && (i_req_type == REQ_SEARCH);
            end
            ST_FIRST: begin
                o_cmd.first = 1'b1;
            end
            ST_PROBE: begin
                o_cmd.probe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_rsp_valid = r_rsp_valid;

    // a result beat always lands with the sequencer back in idle
    a_rsp_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> (r_state == ST_IDLE))
        else $error("result beat while search still running");

    // probing is only entered from the first-entry check or continues itself
    a_probe_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE) |-> ($past(r_state) == ST_FIRST || $past(r_state) == ST_PROBE))
        else $error("probe state entered out of order");

    // a search beat accepted in idle always starts with the first-entry check
    a_search_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept_search |=> (r_state == ST_FIRST))
        else $error("accepted search did not start");

endmodule : stlbs_ctrl

`default_nettype wire

// ===== hdl/stlbs_dp.sv =====
// ----------------------------------------------------------------------------
// stlbs_dp
// Table memory, bisection bounds, probe compare and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module stlbs_dp import stlbs_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire t_req                     i_req,
    input  wire logic [ENTRY_COUNT_W-1:0] i_entry_count,
    output t_dp_sts                       o_sts,
    output t_rsp                          o_rsp
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] r_rdata;
    logic [VALUE_W-1:0] r_key;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_low;
    logic [CW-1:0]      r_hip1;      // high + 1
    logic [IW-1:0]      r_mid;
    logic               r_found;
    logic [POSITION_W-1:0] r_pos;

    logic [CW-1:0] count_sat;
    logic [31:0]   wr_idx_w;
    logic          wr_in_range;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;

    logic [CW-1:0] first_span;
    logic [CW-1:0] first_mid_w;
    logic [IW-1:0] first_mid;

    logic          lt, gt, eq;
    logic [CW-1:0] mid_c;
    logic [CW-1:0] n_low, n_hip1;
    logic [CW-1:0] span, half, next_mid_w;
    logic [IW-1:0] next_mid;
    logic          low_valid;
    logic [31:0]   mid_pos_w, low_pos_w;

    // effective count, saturated to the table size
    always_comb begin
        if (32'(i_entry_count) > 32'(TABLE_DEPTH)) begin
            count_sat = CW'(TABLE_DEPTH);
        end else begin
            count_sat = CW'(i_entry_count);
        end
    end

    assign wr_idx_w    = 32'(i_req.entry_index);
    assign wr_in_range = wr_idx_w < 32'(TABLE_DEPTH);
    assign wr_addr     = wr_idx_w[IW-1:0];

    // first probe: low = 0, high + 1 = count
    assign first_span  = r_count - CW'(1);
    assign first_mid_w = first_span >> 1;
    assign first_mid   = first_mid_w[IW-1:0];

    // probe step
    assign lt    = r_rdata < r_key;
    assign gt    = r_rdata > r_key;
    assign eq    = ~lt & ~gt;
    assign mid_c = CW'(r_mid);

    assign n_low      = lt ? (mid_c + CW'(1)) : r_low;
    assign n_hip1     = gt ? mid_c : r_hip1;
    assign span       = n_hip1 - n_low - CW'(1);
    assign half       = span >> 1;
    assign next_mid_w = n_low + half;
    assign next_mid   = next_mid_w[IW-1:0];
    assign low_valid  = n_low < r_count;

    assign mid_pos_w = 32'(r_mid);
    assign low_pos_w = 32'(n_low);

    always_comb begin
        priority if (i_cmd.first) begin
            rd_addr = first_mid;
        end else if (i_cmd.probe) begin
            rd_addr = next_mid;
        end else begin
            rd_addr = '0;            // entry 0 for a new search
        end
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_write && wr_in_range) begin
            r_mem[wr_addr] <= i_req.entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_search) begin
            r_key   <= i_req.search_key;
            r_count <= count_sat;
        end
        if (i_cmd.first) begin
            r_low   <= '0;
            r_hip1  <= r_count;
            r_mid   <= first_mid;
            r_found <= (r_count != '0);
            r_pos   <= '0;
        end
        if (i_cmd.probe) begin
            r_low  <= n_low;
            r_hip1 <= n_hip1;
            r_mid  <= next_mid;
            if (eq) begin
                r_found <= 1'b1;
                r_pos   <= mid_pos_w[POSITION_W-1:0];
            end else begin
                r_found <= low_valid;
                r_pos   <= low_valid ? low_pos_w[POSITION_W-1:0] : '0;
            end
        end
    end

    assign o_sts.count_zero   = (r_count == '0);
    assign o_sts.key_le_first = (r_key <= r_rdata);
    assign o_sts.hit          = eq;
    assign o_sts.search_end   = ~(n_low < n_hip1);

    assign o_rsp.found    = r_found;
    assign o_rsp.position = r_pos;

    // bounds stay ordered and within the searched range while probing
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe |-> (r_low < r_hip1 && r_hip1 <= r_count))
        else $error("bisection bounds out of order");

    // the probed index lies between the bounds
    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe |-> (mid_c >= r_low && mid_c < r_hip1))
        else $error("probe index outside bounds");

endmodule : stlbs_dp

`default_nettype wire

// ===== hdl/sorted_table_lower_bound_search_core.sv =====
// ----------------------------------------------------------------------------
// sorted_table_lower_bound_search_core
// Lower-bound lookup over a software-maintained sorted table of 64-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a beat (i_req) is taken at a clock edge with start high
//   and busy low. req_type selects a table write or a key search.
//   - Write: stored at entry_index in the same edge; an index at or beyond
//     TABLE_DEPTH is dropped. No result beat; busy stays low, so writes can
//     stream one per cycle.
//   - Search: busy rises for the first-entry check and then for P bisection
//     probes (0 when the key is at or below entry 0 or the table is empty,
//     otherwise at most ceil(log2(count + 1)), 9 for a full 256-entry table).
//     The result beat shows on o_rsp with o_rsp_valid for one cycle, the
//     cycle right after the last compare; busy is already low then, so the
//     next beat may be taken in that cycle. The pace is one table-memory
//     read per cycle: each probe compares the registered read data and
//     issues the next address in the same cycle.
//   Result channel: o_rsp_valid is a one-cycle strobe; the receiver cannot
//   stall, so it must take every result beat as it comes.
//   Config: i_cfg_we writes i_cfg_data into entry_count (saturated to
//   TABLE_DEPTH on use). Write only while no search is running.
//   Reset: synchronous, active low. Clears entry_count and the sequencer.
//   Table contents are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_lower_bound_search_core import stlbs_pkg::*; #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request beat
    input  wire logic                     start,
    output logic                          busy,
    input  wire t_req                     i_req,
    // result beat
    output logic                          o_rsp_valid,
    output t_rsp                          o_rsp,
    // entry_count register
    input  wire logic                     i_cfg_we,
    input  wire logic [ENTRY_COUNT_W-1:0] i_cfg_data
);

    logic [ENTRY_COUNT_W-1:0] r_entry_count;
    t_dp_cmd                  dp_cmd;
    t_dp_sts                  dp_sts;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // sequencer
    stlbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req_type  (i_req.req_type),
        .i_sts       (dp_sts),
        .o_busy      (busy),
        .o_cmd       (dp_cmd),
        .o_rsp_valid (o_rsp_valid)
    );

    // table memory and bisection datapath
    stlbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_req         (i_req),
        .i_entry_count (r_entry_count),
        .o_sts         (dp_sts),
        .o_rsp         (o_rsp)
    );

endmodule : sorted_table_lower_bound_search_core

`default_nettype wire

// ===== test/tb_sorted_table_lower_bound_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_lower_bound_search_core
// Self-checking bench for the sorted-table lower-bound search core.
// ----------------------------------------------------------------------------
// Loads the table, sets entry_count between phases and fires write and search
// beats at the block. A scoreboard keeps its own copy of the table and count,
// works out the lower-bound answer of every accepted search and checks each
// result beat against the oldest answer still due.
// ----------------------------------------------------------------------------

module tb_sorted_table_lower_bound_search_core;
    import stlbs_pkg::*;

    localparam int          DEPTH       = 256;
    localparam int          STALL_LIMIT = 1000;  // cycles with no beat at all
    localparam int          ITEM_TARGET = 1970;  // directed plus random beats
    localparam logic [63:0] ALL_ONES    = {VALUE_W{1'b1}};

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors table and entry_count, predicts the lower bound.
    // ------------------------------------------------------------------------
    class lower_bound_tracker;
        logic [VALUE_W-1:0]       table_mem [DEPTH];
        logic [ENTRY_COUNT_W-1:0] entry_count;
        t_rsp                     answers_due [$];
        int                       mismatches;

        function new();
            entry_count = '0;
            mismatches  = 0;
            foreach (table_mem[i]) table_mem[i] = '0;
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        function t_rsp lower_bound(logic [VALUE_W-1:0] key);
            t_rsp ans;
            int   span;
            int   low;
            int   high;
            int   mid;
            ans  = '0;
            span = (entry_count > DEPTH) ? DEPTH : int'(entry_count);
            if (span == 0) return ans;
            if (key <= table_mem[0]) begin
                ans.found = 1'b1;
                return ans;
            end
            low  = 0;
            high = span - 1;
            while (low <= high) begin
                mid = low + (high - low) / 2;
                if (table_mem[mid] < key) begin
                    low = mid + 1;
                end else if (table_mem[mid] > key) begin
                    high = mid - 1;
                end else begin
                    ans.found    = 1'b1;
                    ans.position = mid[POSITION_W-1:0];
                    return ans;
                end
            end
            if (low < span) begin
                ans.found    = 1'b1;
                ans.position = low[POSITION_W-1:0];
            end
            return ans;
        endfunction

        function void note_request(t_req r);
            if (r.req_type == REQ_WRITE) begin
                table_mem[r.entry_index] = r.entry_value;
            end else begin
                answers_due.push_back(lower_bound(r.search_key));
            end
        endfunction

        task check_answer(t_rsp got);
            t_rsp want;
            if (answers_due.size() == 0) begin
                report($sformatf("result beat with no search pending (found=%0b pos=%0d)",
                                 got.found, got.position));
                return;
            end
            want = answers_due.pop_front();
            if (got.found !== want.found)
                report($sformatf("found: got %0b, want %0b", got.found, want.found));
            if (got.position !== want.position)
                report($sformatf("position: got %0d, want %0d",
                                 got.position, want.position));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT hookup
    // ------------------------------------------------------------------------
    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     start    = 1'b0;
    logic                     busy;
    t_req                     req      = '0;
    logic                     rsp_valid;
    t_rsp                     rsp;
    logic                     cfg_we   = 1'b0;
    logic [ENTRY_COUNT_W-1:0] cfg_data = '0;

    lower_bound_tracker sb = new();
    int                 items_sent  = 0;
    int                 idle_pct    = 35;
    int                 stall_count = 0;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    sorted_table_lower_bound_search_core #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. A request beat and a
    // result beat may land on the same edge (busy is already low in the result
    // cycle); the queue is FIFO so the order of the two calls does not matter.
    // The watchdog counts edges on which nothing moved at all.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) sb.entry_count = cfg_data;
            if (start && !busy) sb.note_request(req);
            if (rsp_valid) sb.check_answer(rsp);
        end
        if ((start && !busy) || rsp_valid || cfg_we) begin
            stall_count = 0;
        end else begin
            stall_count++;
        end
        if (stall_count >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Beat construction. Fields a beat does not use carry random junk, so the
    // block is seen to ignore them.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_req write_beat(logic [ENTRY_INDEX_W-1:0] idx,
                                        logic [VALUE_W-1:0] val);
        t_req r;
        r.req_type    = REQ_WRITE;
        r.entry_index = idx;
        r.entry_value = val;
        r.search_key  = rand64();
        return r;
    endfunction

    function automatic t_req search_beat(logic [VALUE_W-1:0] key);
        t_req r;
        r.req_type    = REQ_SEARCH;
        r.entry_index = ENTRY_INDEX_W'($urandom);
        r.entry_value = rand64();
        r.search_key  = key;
        return r;
    endfunction

    // Present one beat and hold it until taken. Sender idling is per cycle,
    // so gaps land anywhere in a running search. start is assigned once per
    // falling edge; back-to-back beats keep it high.
    task automatic drive_beat(t_req r);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
        if (items_sent >= 2 * ITEM_TARGET / 3) begin
            idle_pct = 0;
        end else if (items_sent >= ITEM_TARGET / 3) begin
            idle_pct = 51;
        end
    endtask

    task automatic store_entry(logic [ENTRY_INDEX_W-1:0] idx, logic [VALUE_W-1:0] val);
        drive_beat(write_beat(idx, val));
    endtask

    task automatic look_up(logic [VALUE_W-1:0] key);
        drive_beat(search_beat(key));
    endtask

    // Drop start and wait until every search has answered. Writes never make
    // the block busy, so a short pause after the last answer is enough.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (sb.answers_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_entry_count(logic [ENTRY_COUNT_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Keys: exact hits are the most common pick (duplicates make the early-hit
    // path matter), with neighbors, both extremes and pure noise mixed in.
    function automatic logic [63:0] pick_key(int span);
        logic [63:0] entry;
        entry = (span == 0) ? rand64() : sb.table_mem[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return rand64();
            3:       return entry - 64'd1;
            4:       return entry + 64'd1;
            default: return entry;
        endcase
    endfunction

    // One phase: set the count, load entries 0..span-1, then run searches
    // with the odd stray write mixed in (a stray write inside the span leaves
    // the table unsorted, which the bisection must still get through).
    task automatic run_table_phase(int count_value);
        int          span;
        int          shape;
        logic [63:0] val;
        logic [63:0] step;
        settle();
        write_entry_count(count_value[ENTRY_COUNT_W-1:0]);
        span  = (count_value > DEPTH) ? DEPTH : count_value;
        shape = $urandom_range(0, 9);
        // 0-3: dense with duplicates, 4-6: wide spread, 7-8: pinned at top,
        // 9: fully unsorted
        if (shape < 4) begin
            val = 64'($urandom) >> $urandom_range(0, 16);
        end else if (shape < 7) begin
            val = rand64() >> $urandom_range(1, 24);
        end else begin
            val = ALL_ONES - 64'($urandom_range(0, 300));
        end
        for (int i = 0; i < span; i++) begin
            if (shape == 9) val = rand64();
            store_entry(i[ENTRY_INDEX_W-1:0], val);
            if (shape < 4) begin
                step = 64'($urandom_range(0, 3));
            end else if (shape < 7) begin
                step = rand64() >> $urandom_range(8, 40);
            end else begin
                step = 64'($urandom_range(0, 2));
            end
            val = (val + step < val) ? ALL_ONES : val + step;
        end
        repeat ($urandom_range(20, 50)) begin
            if ($urandom_range(0, 9) == 0) begin
                store_entry(ENTRY_INDEX_W'($urandom), rand64());
            end else begin
                look_up(pick_key(span));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table: every key misses
        write_entry_count('0);
        look_up('0);
        look_up(ALL_ONES);

        // three-entry table, plus the top index holding the largest value
        store_entry(8'd0, '0);
        store_entry(8'd1, 64'd100);
        store_entry(8'd2, 64'd200);
        store_entry(8'd255, ALL_ONES);
        settle();
        write_entry_count(9'd3);
        look_up('0);        // at or below entry 0
        look_up(64'd100);   // exact hit at the first mid
        look_up(64'd150);   // falls between entries
        look_up(64'd200);   // hit on the last entry
        look_up(64'd201);   // above every entry: miss
        look_up(ALL_ONES);
        look_up(64'd99);
        // break the order: entry 1 now above entry 2
        store_entry(8'd1, 64'd300);
        look_up(64'd250);
        look_up(64'd300);

        // single entry
        settle();
        write_entry_count(9'd1);
        look_up('0);
        look_up(64'd1);
        store_entry(8'd0, ALL_ONES);
        look_up(ALL_ONES);

        // full table, then a count beyond the table (saturates)
        run_table_phase(DEPTH);
        run_table_phase((1 << ENTRY_COUNT_W) - 1);
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                run_table_phase(0);
            end else if (pick < 9) begin
                run_table_phase($urandom_range(DEPTH - 1, (1 << ENTRY_COUNT_W) - 1));
            end else if (pick < 22) begin
                run_table_phase($urandom_range(17, 100));
            end else begin
                run_table_phase($urandom_range(1, 20));
            end
        end

        settle();
        repeat (16) @(posedge clk);
        if (sb.answers_due.size() != 0)
            sb.report($sformatf("%0d search answers never arrived", sb.answers_due.size()));
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/stlbs_pkg.sv
hdl/stlbs_ctrl.sv
hdl/stlbs_dp.sv
hdl/sorted_table_lower_bound_search_core.sv
test/tb_sorted_table_lower_bound_search_core.sv
